>>> hw/rtl/chac_pkg.sv
// chac_pkg: shared types, widths, constants and the CORDIC arctangent table
// for the compass heading block. No dependencies.
package chac_pkg;

   localparam int CORDIC_ITERATIONS_DEF = 16;
   localparam int TABLE_LEN             = 24;
   localparam int ITER_IDX_W            = 5;    // indexes the whole table
   localparam int CSR_INDEX_W           = 8;
   localparam int CSR_DATA_W            = 15;

   localparam logic [CSR_INDEX_W-1:0] CSR_DECLINATION = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIM        = 8'd1;

   typedef struct packed {
      logic signed [15:0] mag_x;
      logic signed [15:0] mag_y;
   } req_type;

   typedef struct packed {
      logic        [14:0] heading;
      logic signed [15:0] seen_min_x;
      logic signed [15:0] seen_max_x;
      logic signed [15:0] seen_min_y;
      logic signed [15:0] seen_max_y;
   } rsp_type;

   // one-hot datapath commands from the controller
   typedef struct packed {
      logic                  load;   // take sample, update extremes
      logic                  prep;   // center, pre-rotate, load CORDIC
      logic                  iter;   // one CORDIC micro-rotation
      logic                  head;   // rotate, declination, first wrap
      logic                  win;    // quadrant window, smoothing sum, trim
      logic                  mul;    // reciprocal multiply for /20
      logic                  fin;    // write smoothed limit
      logic                  out_wr; // load result register
      logic [ITER_IDX_W-1:0] idx;    // CORDIC step index
   } cmd_type;

   // atan(2^-i) in 1/16384 degree
   function automatic logic [19:0] atan_fine(input logic [ITER_IDX_W-1:0] i);
      logic [19:0] r;
      case (i)
         5'd0:  r = 20'd737280;
         5'd1:  r = 20'd435242;
         5'd2:  r = 20'd229970;
         5'd3:  r = 20'd116736;
         5'd4:  r = 20'd58595;
         5'd5:  r = 20'd29326;
         5'd6:  r = 20'd14667;
         5'd7:  r = 20'd7334;
         5'd8:  r = 20'd3667;
         5'd9:  r = 20'd1833;
         5'd10: r = 20'd917;
         5'd11: r = 20'd458;
         5'd12: r = 20'd229;
         5'd13: r = 20'd115;
         5'd14: r = 20'd57;
         5'd15: r = 20'd29;
         5'd16: r = 20'd14;
         5'd17: r = 20'd7;
         5'd18: r = 20'd4;
         5'd19: r = 20'd2;
         5'd20: r = 20'd1;
         default: r = 20'd0;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/chac_ctrl.sv
// chac_ctrl: sequencer for the compass heading block; owns the handshakes.
// Depends on chac_pkg.
module chac_ctrl #(
   parameter int CORDIC_ITERATIONS = chac_pkg::CORDIC_ITERATIONS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output chac_pkg::cmd_type cmd
);
   localparam int ITER_W = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_ITER = 3'd2;
   localparam logic [2:0] ST_HEAD = 3'd3;
   localparam logic [2:0] ST_WIN  = 3'd4;
   localparam logic [2:0] ST_MUL  = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      cmd      = '0;
      cmd.idx  = chac_pkg::ITER_IDX_W'(iter_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            iter_in  = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            cmd.iter = 1'b1;
            iter_in  = iter_ff + 1'b1;
            if (iter_ff == ITER_LAST) state_in = ST_HEAD;
         end
         ST_HEAD: begin
            cmd.head = 1'b1;
            state_in = ST_WIN;
         end
         ST_WIN: begin
            cmd.win  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.out_wr = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_wr)      rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_to_prep: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_PREP)
      else $error("accepted sample did not start preparation");
   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_wr |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.prep, cmd.iter, cmd.head, cmd.win, cmd.mul,
                cmd.fin, cmd.out_wr}))
      else $error("more than one datapath command");
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ITER |-> iter_ff <= ITER_LAST)
      else $error("CORDIC step index out of range");
`endif

endmodule

>>> hw/rtl/chac_datapath.sv
// chac_datapath: calibration state, CORDIC vectoring unit, limit smoothing and
// result register for the compass heading block. Depends on chac_pkg.
module chac_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  chac_pkg::cmd_type                   cmd,
   input  chac_pkg::req_type                   req_data,
   input  logic                                csr_we,
   input  logic [chac_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [chac_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output chac_pkg::rsp_type                   rsp_data
);
   localparam logic [1:0] LIM_Y_POS = 2'd0;
   localparam logic [1:0] LIM_Y_NEG = 2'd1;
   localparam logic [1:0] LIM_X_NEG = 2'd2;
   localparam logic [1:0] LIM_X_POS = 2'd3;

   localparam logic signed [24:0] DEG  = 25'sd16384;
   localparam logic signed [24:0] FULL = 25'sd5898240;
   localparam logic [17:0] RECIP5 = 18'd209716;   // ceil(2^20/5)

   // configuration
   logic signed [7:0]  decl_ff;
   logic signed [14:0] trim_ff;

   // calibration state
   logic signed [15:0] lyp_ff, lyn_ff, lxp_ff, lxn_ff;
   logic signed [15:0] minx_ff, maxx_ff, miny_ff, maxy_ff;
   logic signed [15:0] mx_ff, my_ff;

   // CORDIC
   logic signed [41:0] x_ff, x_in, y_ff, y_in;
   logic signed [23:0] z_ff, z_in;
   logic               zero_ff;

   // post-processing
   logic signed [24:0] h_ff;
   logic               upd_ff;
   logic [1:0]         sel_ff;
   logic signed [20:0] sum_ff;
   logic [35:0]        prod_ff;
   logic [14:0]        heading_ff;
   chac_pkg::rsp_type  out_ff;

   assign rsp_data = out_ff;

   // centering and pre-rotation
   logic signed [18:0] cx, cy;
   logic signed [41:0] sx, sy;
   always_comb begin
      cx = {{2{mx_ff[15]}}, mx_ff, 1'b0} - (19'(lxp_ff) + 19'(lxn_ff));
      cy = {{2{my_ff[15]}}, my_ff, 1'b0} - (19'(lyp_ff) + 19'(lyn_ff));
      sx = {{3{cx[18]}}, cx, 20'd0};
      sy = {{3{cy[18]}}, cy, 20'd0};
   end

   // CORDIC step and loads
   logic signed [41:0] dx, dy;
   logic signed [23:0] at;
   always_comb begin
      dx   = y_ff >>> cmd.idx;
      dy   = x_ff >>> cmd.idx;
      at   = 24'(chac_pkg::atan_fine(cmd.idx));
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (cmd.prep) begin
         if (sx < 0) begin
            if (sy >= 0) begin
               x_in = sy;   y_in = -sx;  z_in = 24'sd1474560;
            end else begin
               x_in = -sy;  y_in = sx;   z_in = -24'sd1474560;
            end
         end else begin
            x_in = sx;   y_in = sy;   z_in = '0;
         end
      end else if (cmd.iter) begin
         if (y_ff > 0) begin
            x_in = x_ff + dx;  y_in = y_ff - dy;  z_in = z_ff + at;
         end else begin
            x_in = x_ff - dx;  y_in = y_ff + dy;  z_in = z_ff - at;
         end
      end
   end

   // rotation, declination, first wrap
   logic signed [24:0] h_raw, h_wrap;
   always_comb begin
      h_raw = (zero_ff ? 25'sd0 : 25'(z_ff)) - 25'sd1474560
              + {{5{decl_ff[7]}}, decl_ff, 12'd0};
      h_wrap = h_raw;
      if (h_wrap < 0)    h_wrap = h_wrap + FULL;
      if (h_wrap > FULL) h_wrap = h_wrap - FULL;
   end

   // quadrant windows, smoothing sum, trim
   logic               upd;
   logic [1:0]         sel;
   logic signed [15:0] old_lim, smp;
   logic signed [20:0] old21, sum;
   logic signed [17:0] h64, h64_t;
   logic signed [24:0] h_rnd;
   always_comb begin
      upd = 1'b1;
      sel = LIM_Y_POS;
      if (h_ff < 20 * DEG || h_ff > 340 * DEG)       sel = LIM_Y_POS;
      else if (h_ff > 160 * DEG && h_ff < 200 * DEG) sel = LIM_Y_NEG;
      else if (h_ff > 70 * DEG && h_ff < 110 * DEG)  sel = LIM_X_NEG;
      else if (h_ff > 250 * DEG && h_ff < 290 * DEG) sel = LIM_X_POS;
      else                                           upd = 1'b0;
      case (sel)
         LIM_Y_POS: begin old_lim = lyp_ff; smp = my_ff; end
         LIM_Y_NEG: begin old_lim = lyn_ff; smp = my_ff; end
         LIM_X_NEG: begin old_lim = lxn_ff; smp = mx_ff; end
         default:   begin old_lim = lxp_ff; smp = mx_ff; end
      endcase
      old21 = 21'(old_lim);
      sum   = (old21 <<< 4) + (old21 <<< 1) + old21 + 21'(smp);
      h_rnd = (h_ff + 25'sd128) >>> 8;
      // heading plus full-range trim reaches 39423: needs 17 bits signed, held in 18
      h64_t = h_rnd[17:0] + 18'(trim_ff);
      h64   = h64_t;
      if (h64 > 18'sd23040) h64 = h64 - 18'sd23040;
      if (h64 < 0)          h64 = h64 + 18'sd23040;
   end

   // truncating divide by 20: floor(floor(|s|/4)/5) via reciprocal
   logic [20:0] mag;
   logic [16:0] q, qs;
   always_comb begin
      mag = sum_ff[20] ? 21'(-sum_ff) : 21'(sum_ff);
      q   = {1'b0, prod_ff[35:20]};
      qs  = sum_ff[20] ? -q : q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decl_ff <= '0;
         trim_ff <= '0;
         lyp_ff  <= 16'sd64;
         lxp_ff  <= 16'sd64;
         lyn_ff  <= -16'sd64;
         lxn_ff  <= -16'sd64;
         minx_ff <= -16'sd64;
         maxx_ff <= 16'sd64;
         miny_ff <= -16'sd64;
         maxy_ff <= 16'sd64;
      end else begin
         if (csr_we) begin
            case (csr_index)
               chac_pkg::CSR_DECLINATION: decl_ff <= csr_wdata[7:0];
               chac_pkg::CSR_TRIM:        trim_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load) begin
            if (req_data.mag_x < minx_ff) minx_ff <= req_data.mag_x;
            if (req_data.mag_x > maxx_ff) maxx_ff <= req_data.mag_x;
            if (req_data.mag_y < miny_ff) miny_ff <= req_data.mag_y;
            if (req_data.mag_y > maxy_ff) maxy_ff <= req_data.mag_y;
         end
         if (cmd.fin && upd_ff) begin
            case (sel_ff)
               LIM_Y_POS: lyp_ff <= qs[15:0];
               LIM_Y_NEG: lyn_ff <= qs[15:0];
               LIM_X_NEG: lxn_ff <= qs[15:0];
               default:   lxp_ff <= qs[15:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mx_ff <= req_data.mag_x;
         my_ff <= req_data.mag_y;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      if (cmd.prep) zero_ff <= (cx == 0) && (cy == 0);
      if (cmd.head) h_ff <= h_wrap;
      if (cmd.win) begin
         upd_ff     <= upd;
         sel_ff     <= sel;
         sum_ff     <= sum;
         heading_ff <= h64[14:0];
      end
      if (cmd.mul) prod_ff <= mag[19:2] * RECIP5;
      if (cmd.out_wr) begin
         out_ff.heading    <= heading_ff;
         out_ff.seen_min_x <= minx_ff;
         out_ff.seen_max_x <= maxx_ff;
         out_ff.seen_min_y <= miny_ff;
         out_ff.seen_max_y <= maxy_ff;
      end
   end

endmodule

>>> hw/rtl/compass_heading_with_auto_calibration.sv
// compass_heading_with_auto_calibration: top level; joins the controller and
// the datapath. Depends on chac_pkg, chac_ctrl and chac_datapath.
//
// Use:
//  - req_ channel: one magnetometer X,Y sample per transfer (valid/stall).
//    req_stall is low only while the block is idle, so one sample is in work
//    at a time.
//  - rsp_ channel: one result per sample: heading in 1/64 degree (0..23040)
//    and the running per-axis extremes including this sample.
//  - csr_ channel: register writes (index 0 declination, index 1 trim);
//    csr_ready is always high, unknown indexes are dropped. Write only while
//    no sample is in work.
//  - Sequence: request transfer, preparation, the CORDIC micro-rotations (one
//    per cycle, iterative), head, window, multiply and finish steps, then the
//    output register write that raises rsp_valid; a new sample waits for idle.
//  - Stall: a finished result waits in the output register; a new sample is
//    accepted meanwhile and its result waits until that register is freed.
//  - Reset (synchronous): limits go to +/-64, extremes to +/-64,
//    declination and trim registers to zero, no result pending.
module compass_heading_with_auto_calibration #(
   parameter int CORDIC_ITERATIONS = chac_pkg::CORDIC_ITERATIONS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  chac_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output chac_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [chac_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [chac_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   chac_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   chac_ctrl #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   chac_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/tb_compass_heading_with_auto_calibration.sv
// Testbench for compass_heading_with_auto_calibration: drives magnetometer samples,
// predicts heading and running extremes in-house, checks every rsp transfer.
// Depends on chac_pkg and the RTL top level only.
module tb_compass_heading_with_auto_calibration;

   localparam int  LATENCY_CYC = chac_pkg::CORDIC_ITERATIONS_DEF + 7;
   localparam int  SETTLE_CYC  = 2 * LATENCY_CYC + 10;
   localparam int  CYCLE_LIMIT = 600000;
   localparam int  NITER       = 16;
   localparam longint FINE_DEG = 16384;
   localparam longint FULL_TURN = 360 * FINE_DEG;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   chac_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   chac_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [chac_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [chac_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   compass_heading_with_auto_calibration uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Heading predictor: own copy of calibration state and registers
   // ---------------------------------------------------------------------
   longint arctan_steps [0:15] = '{737280, 435242, 229970, 116736, 58595, 29326,
                                   14667, 7334, 3667, 1833, 917, 458, 229, 115,
                                   57, 29};
   int lim_ypos, lim_xpos, lim_yneg, lim_xneg;
   int lo_x, hi_x, lo_y, hi_y;
   int decl_q;     // declination, quarter degree
   int trim_64;    // trim, 1/64 degree

   chac_pkg::rsp_type pending_headings [$];
   int      fail_count = 0;
   int      cycle_count = 0;

   // send/receive idle rates in percent
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   bit hold_req = 1'b0;
   int hold_left = 0;

   // CORDIC vectoring angle of (x,y) in 1/16384 degree
   function automatic longint vector_angle(input longint vx, input longint vy);
      longint x, y, z, t, dx, dy;
      x = vx * 1048576;
      y = vy * 1048576;
      z = 0;
      if (vx == 0 && vy == 0) return 0;
      // left half-plane: swing into the right half first
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 90 * FINE_DEG;
         end else begin
            t = x; x = -y; y = t; z = -90 * FINE_DEG;
         end
      end
      for (int i = 0; i < NITER; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += arctan_steps[i];
         end else begin
            x -= dx; y += dy; z -= arctan_steps[i];
         end
      end
      return z;
   endfunction

   function automatic int pull_limit(input int old, input int s);
      return (19 * old + s) / 20;   // truncates toward zero
   endfunction

   function automatic chac_pkg::rsp_type predict_heading(input chac_pkg::req_type s);
      int      mx, my, h64;
      longint  cx, cy, h;
      chac_pkg::rsp_type r;
      mx = s.mag_x;
      my = s.mag_y;
      if (mx < lo_x) lo_x = mx;
      if (mx > hi_x) hi_x = mx;
      if (my < lo_y) lo_y = my;
      if (my > hi_y) hi_y = my;
      cx = 2 * longint'(mx) - (longint'(lim_xpos) + lim_xneg);
      cy = 2 * longint'(my) - (longint'(lim_ypos) + lim_yneg);
      h = vector_angle(cx, cy) - 90 * FINE_DEG + longint'(decl_q) * (FINE_DEG / 4);
      if (h < 0) h += FULL_TURN;
      if (h > FULL_TURN) h -= FULL_TURN;
      // quadrant windows, strict bounds; north covers both sides of 0
      if (h < 20 * FINE_DEG || h > 340 * FINE_DEG) lim_ypos = pull_limit(lim_ypos, my);
      if (h > 160 * FINE_DEG && h < 200 * FINE_DEG) lim_yneg = pull_limit(lim_yneg, my);
      if (h > 70 * FINE_DEG && h < 110 * FINE_DEG) lim_xneg = pull_limit(lim_xneg, mx);
      if (h > 250 * FINE_DEG && h < 290 * FINE_DEG) lim_xpos = pull_limit(lim_xpos, mx);
      h64 = int'((h + 128) >>> 8) + trim_64;
      if (h64 > 23040) h64 -= 23040;
      if (h64 < 0) h64 += 23040;
      r.heading    = h64[14:0];
      r.seen_min_x = lo_x[15:0];
      r.seen_max_x = hi_x[15:0];
      r.seen_min_y = lo_y[15:0];
      r.seen_max_y = hi_y[15:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Clock, cycle limit, receiver stall, result checker
   // ---------------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: random stall, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req = 1'b0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      chac_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_headings.size() == 0) begin
            $error("unexpected rsp transfer: %p", rsp_data);
            fail_count++;
         end else begin
            e = pending_headings.pop_front();
            if (rsp_data.heading !== e.heading) begin
               $error("heading exp %0d got %0d", e.heading, rsp_data.heading);
               fail_count++;
            end
            if (rsp_data.seen_min_x !== e.seen_min_x) begin
               $error("seen_min_x exp %0d got %0d", e.seen_min_x, rsp_data.seen_min_x);
               fail_count++;
            end
            if (rsp_data.seen_max_x !== e.seen_max_x) begin
               $error("seen_max_x exp %0d got %0d", e.seen_max_x, rsp_data.seen_max_x);
               fail_count++;
            end
            if (rsp_data.seen_min_y !== e.seen_min_y) begin
               $error("seen_min_y exp %0d got %0d", e.seen_min_y, rsp_data.seen_min_y);
               fail_count++;
            end
            if (rsp_data.seen_max_y !== e.seen_max_y) begin
               $error("seen_max_y exp %0d got %0d", e.seen_max_y, rsp_data.seen_max_y);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Shared driving tasks
   // ---------------------------------------------------------------------
   // One sample transfer. Valid stays high afterward; release_sender drops it.
   task automatic send_sample(input int x, input int y);
      chac_pkg::req_type s;
      s.mag_x = x[15:0];
      s.mag_y = y[15:0];
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < tx_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (req_stall);
      pending_headings.push_back(predict_heading(s));
   endtask

   task automatic release_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait out every pending result, then the block's own latency
   task automatic drain_results();
      release_sender();
      while (pending_headings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_csr(input logic [chac_pkg::CSR_INDEX_W-1:0] idx,
                            input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[chac_pkg::CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      if (idx == chac_pkg::CSR_DECLINATION) decl_q = $signed(value[7:0]);
      else if (idx == chac_pkg::CSR_TRIM) trim_64 = $signed(value[14:0]);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_calibration(input int decl, input int trim);
      write_csr(chac_pkg::CSR_DECLINATION, decl);
      write_csr(chac_pkg::CSR_TRIM, trim);
   endtask

   // point on a circle around a hard-iron offset, as a rotating sensor sees it
   task automatic send_circle_point(input int ox, input int oy, input int rad);
      real a;
      int  x, y;
      a = $urandom_range(35999) * 3.14159265358979 / 18000.0;
      x = ox + $rtoi(rad * $cos(a)) + $urandom_range(8) - 4;
      y = oy + $rtoi(rad * $sin(a)) + $urandom_range(8) - 4;
      if (x > 32767) x = 32767;
      if (x < -32768) x = -32768;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      send_sample(x, y);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed();
      // zero vector: sample at the reset center
      send_sample(0, 0);
      // one sample per cardinal direction, hits each quadrant window
      send_sample(0, 1000);
      send_sample(1000, 0);
      send_sample(0, -1000);
      send_sample(-1000, 0);
      // left half-plane on both sides of the x axis
      send_sample(-500, 1);
      send_sample(-500, -1);
      send_sample(-500, 0);
      // field extremes
      send_sample(-32768, -32768);
      send_sample(32767, 32767);
      send_sample(-32768, 32767);
      send_sample(32767, -32768);
      send_sample(0, -32768);
      send_sample(-32768, 0);
      drain_results();
      // register extremes: declination and trim at both ends of their range
      set_calibration(-128, -16384);
      send_sample(300, 300);
      send_sample(-300, 200);
      send_sample(10, -400);
      drain_results();
      set_calibration(127, 16383);
      send_sample(300, 300);
      send_sample(-300, 200);
      send_sample(10, -400);
      drain_results();
      set_calibration(0, 11520);
      send_sample(200, -50);
      send_sample(-200, 50);
      drain_results();
   endtask

   // random phase: mostly circle sweeps, some full-range noise
   task automatic test_random_phase(input int n, input int tx_pct, input int rx_pct);
      int ox, oy, rad;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      ox = $urandom_range(4000) - 2000;
      oy = $urandom_range(4000) - 2000;
      rad = $urandom_range(3000) + 50;
      for (int i = 0; i < n; i++) begin
         if (i % 60 == 0) begin
            ox = $urandom_range(8000) - 4000;
            oy = $urandom_range(8000) - 4000;
            rad = ($urandom_range(9) == 0) ? $urandom_range(20000) + 1000
                                             : $urandom_range(3000) + 20;
         end
         if ($urandom_range(99) < 80) send_circle_point(ox, oy, rad);
         else send_sample($urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
      end
      drain_results();
   endtask

   // receiver holds off while samples keep coming, then sender waits for all
   task automatic test_backpressure();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_req = 1'b1;
      for (int i = 0; i < 10; i++) send_circle_point(100, -100, 900);
      drain_results();
      for (int i = 0; i < 5; i++) send_circle_point(100, -100, 900);
      drain_results();
   endtask

   initial begin
      lim_ypos = 64; lim_xpos = 64; lim_yneg = -64; lim_xneg = -64;
      lo_x = -64; hi_x = 64; lo_y = -64; hi_y = 64;
      decl_q = 0; trim_64 = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      set_calibration($urandom_range(255) - 128, $urandom_range(23040) - 11520);
      test_random_phase(300, 23, 47);
      set_calibration(-128, -11520);
      test_random_phase(300, 47, 23);
      set_calibration(127, 11520);
      test_backpressure();
      set_calibration(0, 0);
      test_random_phase(300, 0, 0);
      repeat (SETTLE_CYC) @(posedge clock);

      if (fail_count == 0 && pending_headings.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/chac_pkg.sv
hw/rtl/chac_ctrl.sv
hw/rtl/chac_datapath.sv
hw/rtl/compass_heading_with_auto_calibration.sv
tb/tb_compass_heading_with_auto_calibration.sv
